FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// All checks sample on clk_i and are disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define PD2_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pd2 assertion failed");

// The expression must never be true outside reset.
`define PD2_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("pd2 forbidden condition seen");

`endif

FILE: rtl/pd2spc_pkg.sv
package pd2spc_pkg;

  localparam int QUANTA_BITS = 16;
  localparam int TIME_BITS   = 32;
  localparam int PID_BITS    = 22;

  // Width of period * (index + 1).
  localparam int PROD_W   = 2 * QUANTA_BITS + 1;
  // Widest dividend: slack * period.
  localparam int DIV_W    = PROD_W + QUANTA_BITS;
  localparam int SIDE_W   = TIME_BITS + 3 * QUANTA_BITS + 4;
  // The lane wraps its two dividers with input, middle and output registers.
  localparam int LANE_LAT = 2 * (DIV_W + 1) + 3;
  localparam int TOP_LAT  = LANE_LAT + 1;

  typedef logic [SIDE_W-1:0] side_t;

  // Lane context carried through the deadline division.
  typedef struct packed {
    logic [TIME_BITS-1:0]   rel;
    logic [QUANTA_BITS-1:0] period;
    logic [QUANTA_BITS:0]   ip1;
    logic [QUANTA_BITS-1:0] dv;
    logic                   heavy;
    logic                   ezero;
    logic                   bad;
  } side1_t;

  // Lane context carried through the group deadline division.
  typedef struct packed {
    logic [QUANTA_BITS:0]   pad;
    logic [TIME_BITS-1:0]   rel;
    logic [PROD_W-1:0]      dl;
    logic                   bbit;
    logic                   bad;
  } side2_t;

  // What one lane hands to the merge stage.
  typedef struct packed {
    logic [TIME_BITS-1:0] dl;
    logic                 bbit;
    logic [TIME_BITS-1:0] gdl;
    logic                 bad;
  } lane_res_t;

endpackage

FILE: rtl/pd2spc_div.sv
// Pipelined restoring divider: one quotient bit per stage, one new item per cycle.
module pd2spc_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                vld_i,
  input  logic [pd2spc_pkg::DIV_W-1:0]        dvd_i,
  input  logic [pd2spc_pkg::QUANTA_BITS-1:0]  dvs_i,
  input  pd2spc_pkg::side_t                   side_i,
  output logic                                vld_o,
  output logic [pd2spc_pkg::DIV_W-1:0]        quo_o,
  output logic                                rem_nz_o,
  output pd2spc_pkg::side_t                   side_o
);
  import pd2spc_pkg::*;
  `include "assert_macros.svh"

  logic                   vld_q  [0:DIV_W];
  logic [DIV_W-1:0]       word_q [0:DIV_W];
  logic [QUANTA_BITS-1:0] rem_q  [0:DIV_W];
  logic [QUANTA_BITS-1:0] dvs_q  [0:DIV_W];
  side_t                  side_q [0:DIV_W];

  // Valid bits of the stage chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DIV_W; k++) vld_q[k] <= 1'b0;
    end else begin
      vld_q[0] <= vld_i;
      for (int k = 0; k < DIV_W; k++) vld_q[k+1] <= vld_q[k];
    end
  end

  // The entry stage loads the operands; the remainder starts at zero.
  always_ff @(posedge clk_i) begin
    word_q[0] <= dvd_i;
    rem_q[0]  <= '0;
    dvs_q[0]  <= dvs_i;
    side_q[0] <= side_i;
  end

  // Each stage shifts in one dividend bit and decides one quotient bit.
  for (genvar g = 0; g < DIV_W; g++) begin : g_step
    logic [QUANTA_BITS:0]   trial;
    logic                   ge;
    logic [QUANTA_BITS:0]   diff;

    assign trial = {rem_q[g], word_q[g][DIV_W-1]};
    assign ge    = trial >= {1'b0, dvs_q[g]};
    assign diff  = trial - {1'b0, dvs_q[g]};

    always_ff @(posedge clk_i) begin
      word_q[g+1] <= {word_q[g][DIV_W-2:0], ge};
      rem_q[g+1]  <= ge ? diff[QUANTA_BITS-1:0] : trial[QUANTA_BITS-1:0];
      dvs_q[g+1]  <= dvs_q[g];
      side_q[g+1] <= side_q[g];
    end
  end

  assign vld_o    = vld_q[DIV_W];
  assign quo_o    = word_q[DIV_W];
  assign rem_nz_o = rem_q[DIV_W] != '0;
  assign side_o   = side_q[DIV_W];

  // A finished remainder is always below a nonzero divisor.
  `PD2_ASSERT(rem_below_div_a, vld_q[DIV_W] && dvs_q[DIV_W] != '0 |-> rem_q[DIV_W] < dvs_q[DIV_W])

endmodule

FILE: rtl/pd2spc_lane.sv
// One task lane: subtask deadline, b-bit and group deadline.
module pd2spc_lane (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               vld_i,
  input  logic [pd2spc_pkg::QUANTA_BITS-1:0] cost_i,
  input  logic [pd2spc_pkg::QUANTA_BITS-1:0] period_i,
  input  logic [pd2spc_pkg::QUANTA_BITS-1:0] index_i,
  input  logic [pd2spc_pkg::TIME_BITS-1:0]   release_i,
  output logic                               vld_o,
  output pd2spc_pkg::lane_res_t              res_o
);
  import pd2spc_pkg::*;

  // Input register.
  logic                   in_vld_q;
  logic [QUANTA_BITS-1:0] e_q, p_q, i_q;
  logic [TIME_BITS-1:0]   rel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q   <= cost_i;
    p_q   <= period_i;
    i_q   <= index_i;
    rel_q <= release_i;
  end

  // Numerator of the deadline and the context the later stages need.
  side1_t                 s1_in;
  logic [PROD_W-1:0]      prod1;
  logic [QUANTA_BITS-1:0] div1_dvs;

  always_comb begin
    s1_in.rel    = rel_q;
    s1_in.period = p_q;
    s1_in.ip1    = {1'b0, i_q} + {{QUANTA_BITS{1'b0}}, 1'b1};
    s1_in.heavy  = {e_q, 1'b0} >= {1'b0, p_q};
    s1_in.dv     = (p_q > e_q) ? p_q - e_q : QUANTA_BITS'(1);
    s1_in.ezero  = e_q == '0;
    s1_in.bad    = (e_q > p_q) || (i_q >= e_q);
    prod1        = PROD_W'(p_q) * PROD_W'(s1_in.ip1);
    div1_dvs     = s1_in.ezero ? QUANTA_BITS'(1) : e_q;
  end

  logic             d1_vld;
  logic [DIV_W-1:0] d1_quo;
  logic             d1_nz;
  side_t            d1_side;

  pd2spc_div u_div_dl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (in_vld_q),
    .dvd_i    (DIV_W'(prod1)),
    .dvs_i    (div1_dvs),
    .side_i   (side_t'(s1_in)),
    .vld_o    (d1_vld),
    .quo_o    (d1_quo),
    .rem_nz_o (d1_nz),
    .side_o   (d1_side)
  );

  // Deadline, b-bit and clamped slack, registered before the slack multiply.
  side1_t            s1_out;
  logic              bbit_d;
  logic [PROD_W-1:0] dl_d, slack_d, ip1_w;

  always_comb begin
    s1_out  = side1_t'(d1_side);
    bbit_d  = d1_nz && !s1_out.ezero;
    dl_d    = s1_out.ezero ? '0 : d1_quo[PROD_W-1:0] + PROD_W'(bbit_d);
    ip1_w   = PROD_W'(s1_out.ip1);
    slack_d = (dl_d > ip1_w) ? dl_d - ip1_w : '0;
  end

  logic                   mid_vld_q;
  logic [PROD_W-1:0]      dl_q, slack_q;
  logic                   bbit_q, heavy_q, bad_q;
  logic [QUANTA_BITS-1:0] mp_q, dv_q;
  logic [TIME_BITS-1:0]   mrel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_vld_q <= 1'b0;
    end else begin
      mid_vld_q <= d1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    dl_q    <= dl_d;
    slack_q <= slack_d;
    bbit_q  <= bbit_d;
    heavy_q <= s1_out.heavy;
    bad_q   <= s1_out.bad;
    mp_q    <= s1_out.period;
    dv_q    <= s1_out.dv;
    mrel_q  <= s1_out.rel;
  end

  // Group deadline numerator; light tasks divide zero.
  side2_t           s2_in;
  logic [DIV_W-1:0] prod2;

  always_comb begin
    prod2      = heavy_q ? DIV_W'(slack_q) * DIV_W'(mp_q) : '0;
    s2_in.pad  = '0;
    s2_in.rel  = mrel_q;
    s2_in.dl   = dl_q;
    s2_in.bbit = bbit_q;
    s2_in.bad  = bad_q;
  end

  logic             d2_vld;
  logic [DIV_W-1:0] d2_quo;
  logic             d2_nz;
  side_t            d2_side;

  pd2spc_div u_div_gdl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (mid_vld_q),
    .dvd_i    (prod2),
    .dvs_i    (dv_q),
    .side_i   (side_t'(s2_in)),
    .vld_o    (d2_vld),
    .quo_o    (d2_quo),
    .rem_nz_o (d2_nz),
    .side_o   (d2_side)
  );

  // Absolute times with wrap; a zero group deadline stays zero.
  side2_t               s2_out;
  logic [DIV_W-1:0]     g_full;
  logic [TIME_BITS-1:0] g_rel;
  lane_res_t            res_d;

  always_comb begin
    s2_out      = side2_t'(d2_side);
    g_full      = d2_quo + DIV_W'(d2_nz);
    g_rel       = TIME_BITS'(g_full);
    res_d.dl    = TIME_BITS'(s2_out.dl) + s2_out.rel;
    res_d.bbit  = s2_out.bbit;
    res_d.gdl   = (g_rel != '0) ? g_rel + s2_out.rel : '0;
    res_d.bad   = s2_out.bad;
  end

  logic      out_vld_q;
  lane_res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign vld_o = out_vld_q;
  assign res_o = res_q;

endmodule

FILE: rtl/pd2_subtask_priority_compare_top.sv
// PD^2 subtask priority comparator. A transfer is taken on every cycle with
// start_i high; busy_o is never raised, so one comparison can start each cycle.
// Each result appears on done_o in start order, after the lane pipeline and the
// merge register, and is held for a single cycle only: the receiver cannot
// stall it. Each lane holds two pipelined restoring dividers (one quotient bit
// per stage), one for the subtask deadline and one for the group deadline; the
// merge stage follows the lanes.
module pd2_subtask_priority_compare_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [pd2spc_pkg::QUANTA_BITS-1:0] cost_a_i,
  input  logic [pd2spc_pkg::QUANTA_BITS-1:0] period_a_i,
  input  logic [pd2spc_pkg::QUANTA_BITS-1:0] index_a_i,
  input  logic [pd2spc_pkg::TIME_BITS-1:0]   release_a_i,
  input  logic [pd2spc_pkg::PID_BITS-1:0]    pid_a_i,
  input  logic [pd2spc_pkg::QUANTA_BITS-1:0] cost_b_i,
  input  logic [pd2spc_pkg::QUANTA_BITS-1:0] period_b_i,
  input  logic [pd2spc_pkg::QUANTA_BITS-1:0] index_b_i,
  input  logic [pd2spc_pkg::TIME_BITS-1:0]   release_b_i,
  input  logic [pd2spc_pkg::PID_BITS-1:0]    pid_b_i,
  input  logic                              b_valid_i,
  output logic                              done_o,
  output logic                              a_higher_o,
  output logic [pd2spc_pkg::TIME_BITS-1:0]   deadline_a_o,
  output logic [pd2spc_pkg::TIME_BITS-1:0]   deadline_b_o,
  output logic                              bbit_a_o,
  output logic                              bbit_b_o,
  output logic [pd2spc_pkg::TIME_BITS-1:0]   group_deadline_a_o,
  output logic [pd2spc_pkg::TIME_BITS-1:0]   group_deadline_b_o,
  output logic                              bad_params_o
);
  import pd2spc_pkg::*;
  `include "assert_macros.svh"

  logic      acc;
  logic      va, vb;
  lane_res_t ra, rb;

  assign busy_o = 1'b0;
  assign acc    = start_i && !busy_o;

  pd2spc_lane u_lane_a (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vld_i     (acc),
    .cost_i    (cost_a_i),
    .period_i  (period_a_i),
    .index_i   (index_a_i),
    .release_i (release_a_i),
    .vld_o     (va),
    .res_o     (ra)
  );

  pd2spc_lane u_lane_b (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vld_i     (acc),
    .cost_i    (cost_b_i),
    .period_i  (period_b_i),
    .index_i   (index_b_i),
    .release_i (release_b_i),
    .vld_o     (vb),
    .res_o     (rb)
  );

  // Tie-break fields ride alongside the lanes.
  logic [PID_BITS-1:0] pa_q [0:LANE_LAT-1];
  logic [PID_BITS-1:0] pb_q [0:LANE_LAT-1];
  logic                bv_q [0:LANE_LAT-1];

  always_ff @(posedge clk_i) begin
    pa_q[0] <= pid_a_i;
    pb_q[0] <= pid_b_i;
    bv_q[0] <= b_valid_i;
    for (int k = 1; k < LANE_LAT; k++) begin
      pa_q[k] <= pa_q[k-1];
      pb_q[k] <= pb_q[k-1];
      bv_q[k] <= bv_q[k-1];
    end
  end

  // Merge: an absent task B loses; else wrap-aware deadline order, then b-bit, group deadline, pid.
  logic                 bvl;
  logic [TIME_BITS-1:0] ddiff, gdiff;
  logic                 hi_d, bad_d;

  always_comb begin
    bvl   = bv_q[LANE_LAT-1];
    ddiff = ra.dl - rb.dl;
    gdiff = rb.gdl - ra.gdl;
    hi_d  = !bvl || ddiff[TIME_BITS-1] ||
            (ra.dl == rb.dl &&
             ((ra.bbit && !rb.bbit) ||
              (ra.bbit == rb.bbit &&
               (gdiff[TIME_BITS-1] ||
                (ra.gdl == rb.gdl && pa_q[LANE_LAT-1] < pb_q[LANE_LAT-1])))));
    bad_d = ra.bad || (bvl && rb.bad);
  end

  logic                 done_q, hi_q, bad_q, ba_q, bb_q, bvo_q;
  logic [TIME_BITS-1:0] da_q, db_q, ga_q, gb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= va && vb;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q  <= hi_d;
    bad_q <= bad_d;
    da_q  <= ra.dl;
    db_q  <= rb.dl;
    ba_q  <= ra.bbit;
    bb_q  <= rb.bbit;
    ga_q  <= ra.gdl;
    gb_q  <= rb.gdl;
    bvo_q <= bvl;
  end

  assign done_o             = done_q;
  assign a_higher_o         = hi_q;
  assign deadline_a_o       = da_q;
  assign deadline_b_o       = db_q;
  assign bbit_a_o           = ba_q;
  assign bbit_b_o           = bb_q;
  assign group_deadline_a_o = ga_q;
  assign group_deadline_b_o = gb_q;
  assign bad_params_o       = bad_q;

  // Both lanes stay in lockstep.
  `PD2_ASSERT_NEVER(lanes_skew_a, va != vb)
  // Every result traces back to a transfer accepted on start_i.
  `PD2_ASSERT(done_latency_a, done_o |-> $past(acc, TOP_LAT))
  // An absent task B always loses.
  `PD2_ASSERT(absent_b_loses_a, done_o && !bvo_q |-> a_higher_o)

endmodule
